FILE: hw/rtl/signed_unsigned_divider_64_macros.svh
// Assertion helpers for the divider.
// Every check is clocked on clk and is held off while rst_n is low.
`ifndef SIGNED_UNSIGNED_DIVIDER_64_MACROS_SVH
`define SIGNED_UNSIGNED_DIVIDER_64_MACROS_SVH

// Same-cycle implication.
`define SUD64_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SUD64_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/sud64_pkg.sv
`default_nettype none

package sud64_pkg;

  // Width of the payload fields on the channels
  localparam int PORT_W = 64;

  // Operation codes
  localparam logic OP_UNSIGNED = 1'b0;
  localparam logic OP_SIGNED   = 1'b1;

  typedef logic [PORT_W-1:0] word_t;

endpackage

`default_nettype wire

FILE: hw/rtl/sud64_in_if.sv
`default_nettype none

// Operand channel: one beat carries one division
interface sud64_in_if;
  import sud64_pkg::*;

  logic  valid;
  logic  ready;
  logic  operation;
  word_t dividend;
  word_t divisor;

  modport source (output valid, output operation, output dividend, output divisor,
                  input ready);
  modport sink   (input valid, input operation, input dividend, input divisor,
                  output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/sud64_out_if.sv
`default_nettype none

// Result channel: one beat carries one quotient/remainder pair
interface sud64_out_if;
  import sud64_pkg::*;

  logic  valid;
  logic  ready;
  word_t quotient;
  word_t remainder;
  logic  divide_by_zero;

  modport source (output valid, output quotient, output remainder, output divide_by_zero,
                  input ready);
  modport sink   (input valid, input quotient, input remainder, input divide_by_zero,
                  output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/signed_unsigned_divider_64.sv
// Channel  Dir  Beat contents
// -------  ---  ---------------------------------------------------
// in_ch    in   operation, dividend[63:0], divisor[63:0]
// out_ch   out  quotient[63:0], remainder[63:0], divide_by_zero
//
// One beat accepted per cycle while the skid entry is free; a beat passes the operand
// register, one restoring step per quotient bit, sign fixup and the output register.
// Each quotient bit costs one (DATA_WIDTH+1)-bit subtract in its own stage.
// rst_n is synchronous; it clears the valid bits only.
// A two-entry output buffer (output register plus skid) lets the pipeline keep
// taking beats while a result waits; in_ch.ready drops only when both are full.
`default_nettype none

`include "signed_unsigned_divider_64_macros.svh"

module signed_unsigned_divider_64 #(
  parameter int DATA_WIDTH = 64
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  sud64_in_if.sink    in_ch,
  sud64_out_if.source out_ch
);
  import sud64_pkg::*;

  localparam int W = DATA_WIDTH;

  // pipeline advance: blocked only when the skid entry is occupied
  logic adv;
  logic skid_vld_r;

  // ---------------- operand stage ----------------
  logic         op_signed;
  logic [W-1:0] in_a;
  logic [W-1:0] in_b;
  logic         a_neg;
  logic         b_neg;

  // stage registers, index 0 is the operand stage, index W after the last step
  logic [W:0]   stg_vld_r;
  logic [W-1:0] stg_part_r [W+1];
  logic [W-1:0] stg_nq_r   [W+1];
  logic [W-1:0] stg_d_r    [W+1];
  logic [W:0]   stg_qneg_r;
  logic [W:0]   stg_rneg_r;
  logic [W:0]   stg_dbz_r;

  assign adv         = !skid_vld_r;
  assign in_ch.ready = adv;

  assign op_signed = (in_ch.operation == OP_SIGNED);
  assign in_a      = in_ch.dividend[W-1:0];
  assign in_b      = in_ch.divisor[W-1:0];
  assign a_neg     = op_signed && in_a[W-1];
  assign b_neg     = op_signed && in_b[W-1];

  // take magnitudes and sign decisions
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r[0] <= 1'b0;
    end else if (adv) begin
      stg_vld_r[0] <= in_ch.valid;
    end
    if (adv) begin
      stg_part_r[0] <= '0;
      stg_nq_r[0]   <= a_neg ? (W'(0) - in_a) : in_a;
      stg_d_r[0]    <= b_neg ? (W'(0) - in_b) : in_b;
      stg_qneg_r[0] <= a_neg ^ b_neg;
      stg_rneg_r[0] <= a_neg;
      stg_dbz_r[0]  <= (in_b == '0);
    end
  end

  // ---------------- restoring steps, one quotient bit per stage ----------------
  for (genvar k = 0; k < W; k++) begin : g_step
    logic         top;
    logic [W-1:0] shl;
    logic [W:0]   diff;
    logic         fits;
    logic [W-1:0] part_nxt;
    logic [W-1:0] nq_nxt;

    // partial remainder with carry bit, compared against the divisor
    assign top      = stg_part_r[k][W-1];
    assign shl      = {stg_part_r[k][W-2:0], stg_nq_r[k][W-1]};
    assign diff     = {top, shl} - {1'b0, stg_d_r[k]};
    assign fits     = !diff[W];
    assign part_nxt = fits ? diff[W-1:0] : shl;
    assign nq_nxt   = {stg_nq_r[k][W-2:0], fits};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        stg_vld_r[k+1] <= 1'b0;
      end else if (adv) begin
        stg_vld_r[k+1] <= stg_vld_r[k];
      end
      if (adv) begin
        stg_part_r[k+1] <= part_nxt;
        stg_nq_r[k+1]   <= nq_nxt;
        stg_d_r[k+1]    <= stg_d_r[k];
        stg_qneg_r[k+1] <= stg_qneg_r[k];
        stg_rneg_r[k+1] <= stg_rneg_r[k];
        stg_dbz_r[k+1]  <= stg_dbz_r[k];
      end
    end
  end

  // ---------------- sign fixup ----------------
  logic         fin_vld_r;
  logic [W-1:0] fin_q_r;
  logic [W-1:0] fin_r_r;
  logic         fin_dbz_r;
  logic [W-1:0] fin_q_nxt;
  logic [W-1:0] fin_r_nxt;

  // divide by zero forces all ones; the remainder path already returns the dividend
  assign fin_q_nxt = stg_dbz_r[W]  ? '1 :
                     stg_qneg_r[W] ? (W'(0) - stg_nq_r[W]) : stg_nq_r[W];
  assign fin_r_nxt = stg_rneg_r[W] ? (W'(0) - stg_part_r[W]) : stg_part_r[W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_vld_r <= 1'b0;
    end else if (adv) begin
      fin_vld_r <= stg_vld_r[W];
    end
    if (adv) begin
      fin_q_r   <= fin_q_nxt;
      fin_r_r   <= fin_r_nxt;
      fin_dbz_r <= stg_dbz_r[W];
    end
  end

  // ---------------- output register and skid ----------------
  logic         out_vld_r;
  logic [W-1:0] out_q_r;
  logic [W-1:0] out_r_r;
  logic         out_dbz_r;
  logic [W-1:0] skid_q_r;
  logic [W-1:0] skid_r_r;
  logic         skid_dbz_r;
  logic         out_vld_nxt;
  logic         skid_vld_nxt;
  logic         push;
  logic         take;
  logic         out_load;

  assign push     = adv && fin_vld_r;
  assign take     = out_vld_r && out_ch.ready;
  assign out_load = !out_vld_r || take;

  always_comb begin
    out_vld_nxt  = out_vld_r;
    skid_vld_nxt = skid_vld_r;
    if (out_load) begin
      out_vld_nxt  = skid_vld_r || push;
      skid_vld_nxt = 1'b0;
    end else if (push) begin
      skid_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
    // the older skid beat goes out first
    if (out_load) begin
      if (skid_vld_r) begin
        out_q_r   <= skid_q_r;
        out_r_r   <= skid_r_r;
        out_dbz_r <= skid_dbz_r;
      end else begin
        out_q_r   <= fin_q_r;
        out_r_r   <= fin_r_r;
        out_dbz_r <= fin_dbz_r;
      end
    end else if (push) begin
      skid_q_r   <= fin_q_r;
      skid_r_r   <= fin_r_r;
      skid_dbz_r <= fin_dbz_r;
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.quotient       = PORT_W'(out_q_r);
  assign out_ch.remainder      = PORT_W'(out_r_r);
  assign out_ch.divide_by_zero = out_dbz_r;

  // ---------------- checks ----------------
  `SUD64_ASSERT_IMP(a_skid_behind_out, skid_vld_r, out_vld_r,
                    "skid entry held while output register empty")
  `SUD64_ASSERT_NXT(a_push_lands, push, out_vld_r,
                    "beat left the pipeline but no result is pending")
  `SUD64_ASSERT_IMP(a_dbz_ones, out_vld_r && out_dbz_r, out_q_r == '1,
                    "divide by zero result without all-ones quotient")
  `SUD64_ASSERT_IMP(a_stall_full, !adv, skid_vld_r && out_vld_r,
                    "input stalled with free output buffer space")

endmodule

`default_nettype wire
